FILE: src/sfe_pkg.sv
// Shared types, constants and the pulse scaling function of the frame encoder.
`timescale 1ns / 1ps
`default_nettype none
package sfe_pkg;

    localparam int MAX_CHANNELS = 16;
    localparam int CH_W         = 11;
    localparam int IDX_W        = $clog2(MAX_CHANNELS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int DATA_BYTES   = (MAX_CHANNELS * CH_W) / 8;
    localparam int BUF_W        = 7 + CH_W;
    localparam int BITS_W       = $clog2(BUF_W + 1);
    localparam int DBYTE_W      = $clog2(DATA_BYTES);

    localparam logic [7:0]  SBUS_HEADER    = 8'h0F;
    localparam logic [7:0]  SBUS_FOOTER    = 8'h00;
    localparam logic [7:0]  FLAG_FAILSAFE  = 8'h08;
    localparam logic [15:0] OFFSET_US      = 16'd880;
    localparam logic [15:0] SAT_SPAN_US    = 16'd1280;
    localparam logic [CH_W-1:0] SBUS_MAX   = 11'h7FF;
    localparam logic [15:0] RECIP_5        = 16'd52429;

    localparam logic [CNT_W-1:0] ACTIVE_RESET = 5'd8;
    localparam logic [15:0]      CENTER_RESET = 16'd1500;

    typedef enum logic [1:0] {
        CFG_ACTIVE = 2'd0,
        CFG_CENTER = 2'd1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE,
        ST_CENTER,
        ST_HEAD,
        ST_FETCH,
        ST_LOAD,
        ST_BYTE,
        ST_FLAG,
        ST_FOOT
    } state_t;

    function automatic logic [CH_W-1:0] scale_pulse(input logic [15:0] us);
        logic [15:0] diff;
        logic [13:0] x;
        logic [29:0] prod;
        diff = us - OFFSET_US;
        x    = {diff[10:0], 3'b000};
        prod = 30'(x) * 30'(RECIP_5);
        if (us < OFFSET_US) begin
            scale_pulse = '0;
        end else if (diff >= SAT_SPAN_US) begin
            scale_pulse = SBUS_MAX;
        end else begin
            scale_pulse = prod[28:18];
        end
    endfunction

endpackage
`default_nettype wire

FILE: src/sbus_frame_encoder.sv
// Top level: stores scaled servo channels and emits a 25-byte SBUS frame.
//
// Input words carry one channel pulse width in microseconds (s_pulse_us) and a
// failsafe flag, channels in order from 0. Each accepted word is scaled to an
// 11-bit value by a single shared scaler and written into a 16-entry channel
// memory; the block is busy in its scale state after each accept, so it cannot
// take a new word before the last one is written. The word that supplies the
// last active channel starts the frame: the scaler runs once more for the
// center value, then a sequencer walks the channel memory one entry per fetch
// and shifts out bytes through an 18-bit bit buffer.
// Output words sit in a register; a stalled receiver (m_ready low) holds the
// word and freezes the sequencer. s_ready is low while a frame is being built.
// Configuration writes (cfg_index 0: active channel count, 1: center pulse
// width) are always taken and must be issued while idle. Reset (aresetn low,
// synchronous) restores 8 active channels, a 1500 us center value and channel
// index 0, and drops any pending output word. Channel memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sbus_frame_encoder (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [15:0]                 cfg_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [15:0]                 s_pulse_us,
    input  wire logic                        s_failsafe,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [7:0]                       m_frame_byte,
    output logic                             m_frame_last
);
    import sfe_pkg::*;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       active_reg;
    logic [15:0]            center_reg;
    logic [IDX_W-1:0]       count_reg, count_next;
    logic [15:0]            pulse_reg;
    logic                   failsafe_reg;
    logic [CH_W-1:0]        center_val_reg, center_val_next;
    logic [IDX_W-1:0]       ch_idx_reg, ch_idx_next;
    logic [BUF_W-1:0]       buf_reg, buf_next;
    logic [BITS_W-1:0]      bits_reg, bits_next;
    logic [DBYTE_W-1:0]     dbyte_reg, dbyte_next;
    logic                   m_valid_reg, m_valid_next;
    logic [7:0]             m_byte_reg, m_byte_next;
    logic                   m_last_reg, m_last_next;

    logic [CH_W-1:0]        mem [MAX_CHANNELS];
    logic [CH_W-1:0]        rd_data_reg;
    logic                   mem_we;

    logic [15:0]            scale_in;
    logic [CH_W-1:0]        scale_out;
    logic [CNT_W-1:0]       active_eff;
    logic                   out_free;
    logic [CH_W-1:0]        ch_val;
    logic [BUF_W-1:0]       ch_shifted;

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_frame_last = m_last_reg;
    assign out_free     = !m_valid_reg || m_ready;

    always_comb begin
        if (active_reg == '0) begin
            active_eff = CNT_W'(1);
        end else if (active_reg > CNT_W'(MAX_CHANNELS)) begin
            active_eff = CNT_W'(MAX_CHANNELS);
        end else begin
            active_eff = active_reg;
        end
    end

    assign scale_in  = (state_reg == ST_CENTER) ? center_reg : pulse_reg;
    assign scale_out = scale_pulse(scale_in);
    assign mem_we    = (state_reg == ST_SCALE);

    assign ch_val     = ({1'b0, ch_idx_reg} < active_eff) ? rd_data_reg : center_val_reg;
    assign ch_shifted = BUF_W'(ch_val) << bits_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[count_reg] <= scale_out;
        end
        rd_data_reg <= mem[ch_idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= ACTIVE_RESET;
            center_reg <= CENTER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_ACTIVE: active_reg <= cfg_data[CNT_W-1:0];
                CFG_CENTER: center_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            pulse_reg    <= s_pulse_us;
            failsafe_reg <= s_failsafe;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        center_val_reg <= center_val_next;
        ch_idx_reg     <= ch_idx_next;
        buf_reg        <= buf_next;
        bits_reg       <= bits_next;
        dbyte_reg      <= dbyte_next;
        m_byte_reg     <= m_byte_next;
        m_last_reg     <= m_last_next;
    end

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        center_val_next = center_val_reg;
        ch_idx_next     = ch_idx_reg;
        buf_next        = buf_reg;
        bits_next       = bits_reg;
        dbyte_next      = dbyte_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_byte_next     = m_byte_reg;
        m_last_next     = m_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                if (CNT_W'(count_reg) + CNT_W'(1) < active_eff) begin
                    count_next = count_reg + IDX_W'(1);
                    state_next = ST_IDLE;
                end else begin
                    count_next = '0;
                    state_next = ST_CENTER;
                end
            end
            ST_CENTER: begin
                center_val_next = scale_out;
                state_next      = ST_HEAD;
            end
            ST_HEAD: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = SBUS_HEADER;
                    m_last_next  = 1'b0;
                    ch_idx_next  = '0;
                    buf_next     = '0;
                    bits_next    = '0;
                    dbyte_next   = '0;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                buf_next    = buf_reg | ch_shifted;
                bits_next   = bits_reg + BITS_W'(CH_W);
                ch_idx_next = ch_idx_reg + IDX_W'(1);
                state_next  = ST_BYTE;
            end
            ST_BYTE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = buf_reg[7:0];
                    m_last_next  = 1'b0;
                    buf_next     = buf_reg >> 8;
                    bits_next    = bits_reg - BITS_W'(8);
                    dbyte_next   = dbyte_reg + DBYTE_W'(1);
                    if (dbyte_reg == DBYTE_W'(DATA_BYTES - 1)) begin
                        state_next = ST_FLAG;
                    end else if (bits_reg >= BITS_W'(16)) begin
                        state_next = ST_BYTE;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FLAG: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = failsafe_reg ? FLAG_FAILSAFE : 8'h00;
                    m_last_next  = 1'b0;
                    state_next   = ST_FOOT;
                end
            end
            ST_FOOT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = SBUS_FOOTER;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_last_is_footer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> m_frame_byte == SBUS_FOOTER)
        else $error("last word is not the footer");

    a_bits_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BYTE |-> bits_reg >= BITS_W'(8) && bits_reg <= BITS_W'(BUF_W))
        else $error("bit buffer holds too few or too many bits");

    a_accept_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_SCALE && !s_ready)
        else $error("accepted word not scaled next cycle");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_byte) && $stable(m_frame_last))
        else $error("stalled output word changed");

    a_header_first: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_HEAD && out_free |=> m_valid && m_frame_byte == SBUS_HEADER)
        else $error("frame does not start with header");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the SBUS frame encoder: random channel words against a frame predictor.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import sfe_pkg::*;

    localparam int    HALF_PERIOD    = 6;
    localparam int    RESET_CYCLES   = 4;
    localparam int    SETTLE_CYCLES  = 8;
    localparam int    DRAIN_CYCLES   = 80;
    localparam int    WATCHDOG_LIMIT = 4000;
    localparam int    FRAME_DATA     = 22;
    localparam int    NUM_PHASES     = 7;
    localparam int    PHASE_WORDS    = 27;
    localparam int    PULSE_FLOOR_US = 880;
    localparam int    SBUS_TOP       = 2047;

    typedef struct packed {
        logic [15:0] pulse_us;
        logic        failsafe;
    } channel_word_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } frame_word_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = CFG_ACTIVE;
    logic [15:0] cfg_data     = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [15:0] s_pulse_us   = '0;
    logic        s_failsafe   = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_frame_byte;
    logic        m_frame_last;

    channel_word_t pulses_pending [$];
    frame_word_t   frame_words_due [$];
    channel_word_t next_word;
    frame_word_t   want;

    logic [4:0]    active_reg   = ACTIVE_RESET;
    logic [15:0]   center_reg   = CENTER_RESET;
    logic [10:0]   sbus_store [MAX_CHANNELS];
    logic [4:0]    stored_count = '0;

    int src_idle_pct  = 20;
    int snk_stall_pct = 20;
    int src_gap       = 0;
    int snk_gap       = 0;
    int quiet_cycles  = 0;
    int mismatches    = 0;

    sbus_frame_encoder DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pulse_us  (s_pulse_us),
        .s_failsafe  (s_failsafe),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_frame_byte(m_frame_byte),
        .m_frame_last(m_frame_last)
    );

    always #HALF_PERIOD aclk = ~aclk;

    function automatic logic [10:0] scale_to_sbus(input logic [15:0] us);
        int unsigned v;
        if (int'(us) < PULSE_FLOOR_US) begin
            return '0;
        end
        v = (int'(us) - PULSE_FLOOR_US) * 8 / 5;
        if (v > SBUS_TOP) begin
            return 11'(SBUS_TOP);
        end
        return v[10:0];
    endfunction

    task automatic absorb_channel(input logic [15:0] us, input logic failsafe);
        logic [4:0]   eff;
        logic [3:0]   slot;
        logic [10:0]  center_val;
        logic [175:0] packed_bits;
        eff = active_reg;
        if (eff == 0) begin
            eff = 5'd1;
        end
        if (eff > MAX_CHANNELS) begin
            eff = 5'(MAX_CHANNELS);
        end
        slot = stored_count[3:0];
        sbus_store[slot] = scale_to_sbus(us);
        if (int'(slot) + 1 < int'(eff)) begin
            stored_count = 5'(int'(slot) + 1);
        end else begin
            stored_count = '0;
            center_val = scale_to_sbus(center_reg);
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                packed_bits[i*CH_W +: CH_W] = (i < int'(eff)) ? sbus_store[i] : center_val;
            end
            frame_words_due.push_back('{SBUS_HEADER, 1'b0});
            for (int k = 0; k < FRAME_DATA; k++) begin
                frame_words_due.push_back('{packed_bits[k*8 +: 8], 1'b0});
            end
            frame_words_due.push_back('{failsafe ? FLAG_FAILSAFE : 8'h00, 1'b0});
            frame_words_due.push_back('{SBUS_FOOTER, 1'b1});
        end
    endtask

    task automatic queue_word(input logic [15:0] us, input logic failsafe);
        pulses_pending.push_back('{us, failsafe});
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        if (idx == CFG_ACTIVE) begin
            active_reg = val[4:0];
        end else begin
            center_reg = val;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        do @(negedge aclk);
        while (pulses_pending.size() != 0 || s_valid || frame_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] random_pulse();
        case ($urandom_range(3))
            0: return 16'($urandom_range(16'hFFFF));
            1, 2: return 16'($urandom_range(2200, 850));
            default: begin
                case ($urandom_range(7))
                    0: return 16'd0;
                    1: return 16'd879;
                    2: return 16'd880;
                    3: return 16'd881;
                    4: return 16'd2159;
                    5: return 16'd2160;
                    6: return 16'd2161;
                    default: return 16'hFFFF;
                endcase
            end
        endcase
    endfunction

    function automatic int random_pct();
        case ($urandom_range(2))
            0: return 0;
            1: return 10;
            default: return 35;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap = 0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                absorb_channel(s_pulse_us, s_failsafe);
            end
            if (src_gap > 0) begin
                src_gap--;
                s_valid <= 1'b0;
            end else if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
                src_gap = $urandom_range(16);
                s_valid <= 1'b0;
            end else if (pulses_pending.size() != 0) begin
                next_word = pulses_pending.pop_front();
                s_valid    <= 1'b1;
                s_pulse_us <= next_word.pulse_us;
                s_failsafe <= next_word.failsafe;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            snk_gap = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (frame_words_due.size() == 0) begin
                    $error("unexpected frame word: frame_byte %h, frame_last %b",
                           m_frame_byte, m_frame_last);
                    mismatches++;
                end else begin
                    want = frame_words_due.pop_front();
                    if (m_frame_byte !== want.data) begin
                        $error("frame_byte: expected %h, actual %h", want.data, m_frame_byte);
                        mismatches++;
                    end
                    if (m_frame_last !== want.last) begin
                        $error("frame_last: expected %b, actual %b", want.last, m_frame_last);
                        mismatches++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_ready <= 1'b0;
            end else if (snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct) begin
                snk_gap = $urandom_range(16);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        logic [15:0] active_plan [NUM_PHASES];
        logic [15:0] center_plan [NUM_PHASES];
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            sbus_store[i] = '0;
        end
        active_plan = '{16'd1, 16'd16, 16'd31, 16'd3, 16'hFFE6,
                        16'($urandom_range(16, 1)), 16'd12};
        center_plan = '{16'($urandom_range(16'hFFFF)), 16'd0, 16'hFFFF, 16'd880,
                        16'd2160, 16'($urandom_range(2200, 800)), 16'd1500};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        queue_word(16'd0, 1'b0);
        queue_word(16'd879, 1'b0);
        queue_word(16'd880, 1'b0);
        queue_word(16'd881, 1'b0);
        queue_word(16'd1500, 1'b0);
        queue_word(16'd2159, 1'b0);
        queue_word(16'd2160, 1'b0);
        queue_word(16'hFFFF, 1'b1);
        settle();

        write_reg(CFG_ACTIVE, 16'd0);
        write_reg(CFG_CENTER, 16'hFFFF);
        queue_word(16'd1000, 1'b1);
        queue_word(16'd2200, 1'b0);
        settle();

        // open a five-channel frame, then shrink the channel count mid-frame
        write_reg(CFG_ACTIVE, 16'd5);
        write_reg(CFG_CENTER, 16'd0);
        queue_word(16'd1234, 1'b0);
        queue_word(16'd1900, 1'b1);
        queue_word(16'd950, 1'b0);
        settle();
        write_reg(CFG_ACTIVE, 16'd2);
        queue_word(16'd1700, 1'b1);
        settle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1) begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end else begin
                src_idle_pct  = random_pct();
                snk_stall_pct = random_pct();
            end
            write_reg(CFG_ACTIVE, active_plan[p]);
            write_reg(CFG_CENTER, center_plan[p]);
            repeat (PHASE_WORDS) begin
                queue_word(random_pulse(), 1'($urandom_range(1)));
            end
            settle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && frame_words_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
